/* design/rgb2ycc_pkg.sv */
package rgb2ycc_pkg;

    localparam int NUM_TERMS = 9;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 3;

    // Matrix numerators over 10000; rows Y, U, V; columns R, G, B.
    localparam int MAT_NUM [NUM_TERMS] = '{
         2990,  5870,  1140,
        -1687, -3313,  5000,
         5000, -4187,  -813
    };

    localparam longint COEF_DEN = 64'd2550000;

    localparam int SCALE_FULL          = 255;
    localparam int SCALE_LUMA_STUDIO   = 219;
    localparam int SCALE_CHROMA_STUDIO = 224;

    localparam int OFFSET_LUMA_FULL   = 0;
    localparam int OFFSET_LUMA_STUDIO = 16;
    localparam int OFFSET_CHROMA      = 128;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // Round-half-up of |num| * scale / 255 / 10000 * 2^frac, sign applied after.
    function automatic longint coef_fixed(input int num, input int scale, input int frac);
        longint mag;
        longint prod;
        longint q;
        mag  = (num < 0) ? -longint'(num) : longint'(num);
        prod = mag * longint'(scale) * (longint'(1) << frac);
        q    = (2 * prod + COEF_DEN) / (2 * COEF_DEN);
        return (num < 0) ? -q : q;
    endfunction

endpackage

/* design/rgb2ycc_pix_if.sv */
interface rgb2ycc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* design/rgb2ycc_ycc_if.sv */
interface rgb2ycc_ycc_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;

    modport source (output valid, output luma, output blue_diff, output red_diff, input ready);
    modport sink   (input valid, input luma, input blue_diff, input red_diff, output ready);
endinterface

/* design/rgb2ycc_cfg_if.sv */
interface rgb2ycc_cfg_if;
    logic valid;
    logic ready;
    logic studio_range;

    modport source (output valid, output studio_range, input ready);
    modport sink   (input valid, input studio_range, output ready);
endinterface

/* design/rgb_to_ycbcr_converter.sv */
// BT.601 RGB to YCbCr converter. One 8-bit RGB pixel request in, one 8-bit
// Y/Cb/Cr request out. Fully pipelined: a pixel can be accepted every clock
// unless backpressure from the output stalls the pipeline, and each pixel
// passes through four register stages (input register, nine parallel
// coefficient multipliers, row adders with rounding, clamp and output
// register). Each stage holds under backpressure and bubbles close up.
// studio_range selects full range (0) or studio swing (1); write it only while
// no pixel is in flight. FRAC_BITS sets coefficient precision (12..24).
module rgb_to_ycbcr_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rgb2ycc_cfg_if.sink          i_cfg,
    rgb2ycc_pix_if.sink          i_pix,
    rgb2ycc_ycc_if.source        o_ycc
);

    localparam int PW = FRAC_BITS + 11;

    logic                 r_studio;
    logic                 mul_valid;
    logic                 acc_ready;
    logic signed [PW-1:0] mul_prod [rgb2ycc_pkg::NUM_TERMS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_studio <= 1'b0;
        end else if (i_cfg.valid) begin
            r_studio <= i_cfg.studio_range;
        end
    end

    rgb2ycc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_studio (r_studio),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_red    (i_pix.red),
        .i_green  (i_pix.green),
        .i_blue   (i_pix.blue),
        .o_valid  (mul_valid),
        .i_ready  (acc_ready),
        .o_prod   (mul_prod)
    );

    rgb2ycc_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_studio    (r_studio),
        .i_valid     (mul_valid),
        .o_ready     (acc_ready),
        .i_prod      (mul_prod),
        .o_valid     (o_ycc.valid),
        .i_ready     (o_ycc.ready),
        .o_luma      (o_ycc.luma),
        .o_blue_diff (o_ycc.blue_diff),
        .o_red_diff  (o_ycc.red_diff)
    );

endmodule

/* design/rgb2ycc_mul.sv */
module rgb2ycc_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_studio,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [FRAC_BITS+10:0] o_prod [rgb2ycc_pkg::NUM_TERMS]
);

    localparam int CW = FRAC_BITS + 2;
    localparam int PW = FRAC_BITS + 11;

    logic                   r_a_valid;
    logic [7:0]             r_a_comp [rgb2ycc_pkg::NUM_COLS];
    logic                   r_b_valid;
    logic signed [PW-1:0]   r_b_prod [rgb2ycc_pkg::NUM_TERMS];
    logic signed [PW-1:0]   n_b_prod [rgb2ycc_pkg::NUM_TERMS];
    logic                   a_ready;
    logic                   b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_comp[0] <= i_red;
            r_a_comp[1] <= i_green;
            r_a_comp[2] <= i_blue;
        end
    end

    for (genvar k = 0; k < rgb2ycc_pkg::NUM_TERMS; k++) begin : g_term
        localparam longint C_FULL = rgb2ycc_pkg::coef_fixed(
            rgb2ycc_pkg::MAT_NUM[k], rgb2ycc_pkg::SCALE_FULL, FRAC_BITS);
        localparam longint C_STUDIO = rgb2ycc_pkg::coef_fixed(
            rgb2ycc_pkg::MAT_NUM[k],
            (k < rgb2ycc_pkg::NUM_COLS) ? rgb2ycc_pkg::SCALE_LUMA_STUDIO
                                        : rgb2ycc_pkg::SCALE_CHROMA_STUDIO,
            FRAC_BITS);
        localparam logic signed [CW-1:0] COEF_FULL   = CW'(C_FULL);
        localparam logic signed [CW-1:0] COEF_STUDIO = CW'(C_STUDIO);

        logic signed [CW-1:0] w_coef;
        logic signed [PW-1:0] w_coef_ext;
        logic signed [PW-1:0] w_comp_ext;

        assign w_coef     = i_studio ? COEF_STUDIO : COEF_FULL;
        assign w_coef_ext = PW'(w_coef);
        assign w_comp_ext = PW'($signed({1'b0, r_a_comp[k % rgb2ycc_pkg::NUM_COLS]}));
        assign n_b_prod[k] = w_coef_ext * w_comp_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_prod <= n_b_prod;
        end
    end

    assign o_valid = r_b_valid;
    assign o_prod  = r_b_prod;

endmodule

/* design/rgb2ycc_acc.sv */
module rgb2ycc_acc #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_studio,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [FRAC_BITS+10:0] i_prod [rgb2ycc_pkg::NUM_TERMS],
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_luma,
    output logic [7:0]                   o_blue_diff,
    output logic [7:0]                   o_red_diff
);

    localparam int AW = FRAC_BITS + 11;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [AW-1:0] OFF_LUMA_FULL =
        AW'(rgb2ycc_pkg::OFFSET_LUMA_FULL) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] OFF_LUMA_STUDIO =
        AW'(rgb2ycc_pkg::OFFSET_LUMA_STUDIO) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] OFF_CHROMA =
        AW'(rgb2ycc_pkg::OFFSET_CHROMA) <<< FRAC_BITS;

    logic                 r_c_valid;
    logic signed [AW-1:0] r_c_sum [rgb2ycc_pkg::NUM_ROWS];
    logic signed [AW-1:0] n_c_sum [rgb2ycc_pkg::NUM_ROWS];
    logic                 r_d_valid;
    logic [7:0]           r_d_out [rgb2ycc_pkg::NUM_ROWS];
    logic [7:0]           n_d_out [rgb2ycc_pkg::NUM_ROWS];
    logic                 c_ready;
    logic                 d_ready;

    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    for (genvar r = 0; r < rgb2ycc_pkg::NUM_ROWS; r++) begin : g_row
        logic signed [AW-1:0] w_off;
        if (r == 0) begin : g_luma
            assign w_off = i_studio ? OFF_LUMA_STUDIO : OFF_LUMA_FULL;
        end else begin : g_chroma
            assign w_off = OFF_CHROMA;
        end

        assign n_c_sum[r] = AW'(i_prod[3*r]) + AW'(i_prod[3*r+1])
                          + AW'(i_prod[3*r+2]) + w_off + HALF;

        // sum already carries the rounding half
        always_comb begin
            if (r_c_sum[r][AW-1]) begin
                n_d_out[r] = 8'd0;
            end else if (|r_c_sum[r][AW-2:FRAC_BITS+8]) begin
                n_d_out[r] = rgb2ycc_pkg::PIX_MAX;
            end else begin
                n_d_out[r] = r_c_sum[r][FRAC_BITS+7:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_valid <= i_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && i_valid) begin
            r_c_sum <= n_c_sum;
        end
        if (d_ready && r_c_valid) begin
            r_d_out <= n_d_out;
        end
    end

    assign o_valid     = r_d_valid;
    assign o_luma      = r_d_out[0];
    assign o_blue_diff = r_d_out[1];
    assign o_red_diff  = r_d_out[2];

endmodule

/* dv/rgb_to_ycbcr_converter_tb.sv */
`timescale 1ns / 100ps

module rgb_to_ycbcr_converter_tb;

    localparam int FRAC_BITS = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
    } t_ycc;

    // BT.601 matrix over 10000; rows Y, U, V; columns R, G, B.
    localparam int BT601_NUM [9] = '{
         2990,  5870,  1140,
        -1687, -3313,  5000,
         5000, -4187,  -813
    };

    class ycc_scoreboard;
        t_ycc   expected_q[$];
        bit     studio;
        int     errors;
        longint coef [3][3];
        longint offset [3];

        function new();
            errors = 0;
            set_mode(1'b0);
        endfunction

        // |num| * scale / (255 * 10000) in fixed point, rounded half up, sign after.
        function longint scaled_coef(int num, int scale);
            longint mag;
            longint q;
            mag = (num < 0) ? -longint'(num) : longint'(num);
            q = (mag * scale * (longint'(1) <<< FRAC_BITS) + 64'd1275000) / 64'd2550000;
            return (num < 0) ? -q : q;
        endfunction

        function void set_mode(bit studio_range);
            int scale;
            studio = studio_range;
            for (int row = 0; row < 3; row++) begin
                if (studio) begin
                    scale = (row == 0) ? 219 : 224;
                    offset[row] = (row == 0) ? 16 : 128;
                end else begin
                    scale = 255;
                    offset[row] = (row == 0) ? 0 : 128;
                end
                offset[row] = offset[row] <<< FRAC_BITS;
                for (int col = 0; col < 3; col++)
                    coef[row][col] = scaled_coef(BT601_NUM[row * 3 + col], scale);
            end
        endfunction

        function logic [7:0] round_sat(longint acc);
            longint t;
            t = acc + (longint'(1) <<< (FRAC_BITS - 1));
            if (t < 0)
                return 8'd0;
            t = t >>> FRAC_BITS;
            return (t > 255) ? 8'd255 : t[7:0];
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint comp [3];
            longint acc;
            logic [7:0] res [3];
            t_ycc exp_ycc;
            comp[0] = r;
            comp[1] = g;
            comp[2] = b;
            for (int row = 0; row < 3; row++) begin
                acc = offset[row];
                for (int col = 0; col < 3; col++)
                    acc += coef[row][col] * comp[col];
                res[row] = round_sat(acc);
            end
            exp_ycc.luma = res[0];
            exp_ycc.blue_diff = res[1];
            exp_ycc.red_diff = res[2];
            expected_q.push_back(exp_ycc);
        endfunction

        function void check_result(t_ycc got);
            t_ycc exp_ycc;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual Y=%0d U=%0d V=%0d",
                         $time, got.luma, got.blue_diff, got.red_diff);
                errors++;
                return;
            end
            exp_ycc = expected_q.pop_front();
            if (got.luma !== exp_ycc.luma) begin
                $display("%0t: luma mismatch: expected %0d, actual %0d",
                         $time, exp_ycc.luma, got.luma);
                errors++;
            end
            if (got.blue_diff !== exp_ycc.blue_diff) begin
                $display("%0t: blue_diff mismatch: expected %0d, actual %0d",
                         $time, exp_ycc.blue_diff, got.blue_diff);
                errors++;
            end
            if (got.red_diff !== exp_ycc.red_diff) begin
                $display("%0t: red_diff mismatch: expected %0d, actual %0d",
                         $time, exp_ycc.red_diff, got.red_diff);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    bit   src_idle;
    bit   snk_idle;

    ycc_scoreboard board;

    rgb2ycc_cfg_if cfg_bus ();
    rgb2ycc_pix_if pix_bus ();
    rgb2ycc_ycc_if ycc_bus ();

    rgb_to_ycbcr_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_pix  (pix_bus),
        .o_ycc  (ycc_bus)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** rgb_to_ycbcr_converter: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= r;
        pix_bus.green <= g;
        pix_bus.blue  <= b;
        do @(posedge i_clk); while (!pix_bus.ready);
        board.note_pixel(r, g, b);
    endtask

    // Stop sending and wait until every pending request has come back.
    task automatic drain();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit studio_range);
        @(negedge i_clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.studio_range <= studio_range;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.set_mode(studio_range);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_directed();
        logic [23:0] corners [12] = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
            24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'h808080, 24'h7F7F7F, 24'h01FE01, 24'hAA55AA
        };
        foreach (corners[i])
            send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_comp(), rand_comp(), rand_comp());
    endtask

    // Result sink with random backpressure.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = snk_idle ? $urandom_range(0, 4) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                ycc_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            ycc_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!ycc_bus.valid);
            board.check_result({ycc_bus.luma, ycc_bus.blue_diff, ycc_bus.red_diff});
        end
    end

    initial begin
        board = new();
        cycle_count = 0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.studio_range = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.red = '0;
        pix_bus.green = '0;
        pix_bus.blue = '0;
        ycc_bus.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the mode is full range.
        run_directed();
        drain();
        write_mode(1'b1);
        run_directed();
        drain();

        write_mode(1'b0);
        run_random(240);
        drain();

        write_mode(1'b1);
        src_idle = 1'b0;
        run_random(240);
        drain();

        write_mode(1'b0);
        src_idle = 1'b1;
        snk_idle = 1'b0;
        run_random(230);
        drain();

        write_mode(1'b1);
        src_idle = 1'b0;
        run_random(120);
        src_idle = 1'b1;
        snk_idle = 1'b1;
        run_random(120);
        drain();

        if (board.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("** rgb_to_ycbcr_converter: PASSED **");
        end else begin
            $display("** rgb_to_ycbcr_converter: FAILED **");
        end
        $finish;
    end

endmodule
